// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the frame parser rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition violated");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

`endif

// ===== hw/rtl/imfp_pkg.sv =====
// types and constants of the imu message frame parser
// no dependencies
package imfp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [BYTE_W-1:0] PAYLOAD_CAP = 8'd254;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUS_ID = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   localparam logic [BYTE_W-1:0] RST_START_BYTE = 8'd250;
   localparam logic [BYTE_W-1:0] RST_BUS_ID = 8'd255;
   localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD = 8'd254;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_BUS  = 3'd1,
      PH_ID   = 3'd2,
      PH_LEN  = 3'd3,
      PH_DATA = 3'd4,
      PH_SUM  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BUS_ID   = 2'd1,
      ERR_TOO_LONG = 2'd2,
      ERR_CHECKSUM = 2'd3
   } error_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [BYTE_W-1:0] bus_id;
      logic [BYTE_W-1:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_index;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_done;
      error_type         error_kind;
      logic [BYTE_W-1:0] msg_id;
      logic [BYTE_W-1:0] msg_len;
   } result_type;

endpackage

// ===== hw/rtl/imfp_csr.sv =====
// configuration registers of the frame parser: start byte, bus id, payload limit
// depends on imfp_pkg
module imfp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [imfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [imfp_pkg::BYTE_W-1:0]      csr_wdata,
   output imfp_pkg::cfg_type                cfg
);
   import imfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_BYTE:  cfg_in.start_byte = csr_wdata;
            CSR_BUS_ID:      cfg_in.bus_id = csr_wdata;
            CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= RST_START_BYTE;
         cfg_ff.bus_id <= RST_BUS_ID;
         cfg_ff.max_payload <= RST_MAX_PAYLOAD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/imfp_parse.sv =====
// frame state machine: phase, frame fields, payload counter and checksum
// depends on imfp_pkg and assert_macros.svh
`include "assert_macros.svh"

module imfp_parse (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [imfp_pkg::BYTE_W-1:0] in_byte,
   input  imfp_pkg::cfg_type           cfg,
   output imfp_pkg::result_type        result
);
   import imfp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] frame_id_ff, frame_id_in;
   logic [BYTE_W-1:0] frame_len_ff, frame_len_in;
   logic [BYTE_W-1:0] byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] running_sum_ff, running_sum_in;
   logic [BYTE_W-1:0] sum;
   logic [BYTE_W-1:0] limit;

   assign sum = running_sum_ff + in_byte;
   assign limit = (cfg.max_payload < PAYLOAD_CAP) ? cfg.max_payload : PAYLOAD_CAP;

   always_comb begin
      phase_in = phase_ff;
      frame_id_in = frame_id_ff;
      frame_len_in = frame_len_ff;
      byte_count_in = byte_count_ff;
      running_sum_in = running_sum_ff;
      result = '0;
      case (phase_ff)
         PH_BUS: begin
            running_sum_in = sum;
            if (in_byte != cfg.bus_id) begin
               result.error_kind = ERR_BUS_ID;
               phase_in = PH_HUNT;
            end else begin
               phase_in = PH_ID;
            end
         end
         PH_ID: begin
            running_sum_in = sum;
            frame_id_in = in_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            running_sum_in = sum;
            if (in_byte > limit) begin
               result.error_kind = ERR_TOO_LONG;
               phase_in = PH_HUNT;
            end else begin
               frame_len_in = in_byte;
               byte_count_in = '0;
               phase_in = (in_byte == '0) ? PH_SUM : PH_DATA;
            end
         end
         PH_DATA: begin
            running_sum_in = sum;
            result.payload_valid = 1'b1;
            result.payload_index = byte_count_ff;
            result.payload_byte = in_byte;
            byte_count_in = byte_count_ff + 1'b1;
            if (byte_count_in >= frame_len_ff) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            running_sum_in = sum;
            if (sum == '0) begin
               result.frame_done = 1'b1;
            end else begin
               result.error_kind = ERR_CHECKSUM;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
            if (in_byte == cfg.start_byte) begin
               phase_in = PH_BUS;
               running_sum_in = '0;
               frame_id_in = '0;
               frame_len_in = '0;
               byte_count_in = '0;
            end
         end
      endcase
      result.msg_id = frame_id_in;
      result.msg_len = frame_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         frame_id_ff <= '0;
         frame_len_ff <= '0;
         byte_count_ff <= '0;
         running_sum_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         frame_id_ff <= frame_id_in;
         frame_len_ff <= frame_len_in;
         byte_count_ff <= byte_count_in;
         running_sum_ff <= running_sum_in;
      end
   end

   `ASSERT_IMPLY(a_data_len_nonzero, clock, reset, phase_ff == PH_DATA, frame_len_ff != '0)
   `ASSERT_IMPLY(a_data_count_in_range, clock, reset, phase_ff == PH_DATA,
                 byte_count_ff < frame_len_ff)
   `ASSERT_IMPLY(a_done_has_no_error, clock, reset, step && result.frame_done,
                 result.error_kind == ERR_NONE && !result.payload_valid)

endmodule

// ===== hw/rtl/imu_message_frame_parser_core.sv =====
// top level of the imu message frame parser: input register, frame parser, result register
// depends on imfp_pkg, imfp_csr and imfp_parse

// Takes one received byte per transaction and emits exactly one result transaction per
// byte: payload bytes with their index, a done flag on a good checksum, and an error code
// for a wrong bus id, an over-long length or a bad checksum. A byte is taken every cycle
// when the result side keeps up; each byte passes through the input register and then the
// result register, with the frame state machine between them updating on each byte.
// Configuration writes are always ready and take effect from the next byte.
module imu_message_frame_parser_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [imfp_pkg::BYTE_W-1:0]      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_payload_valid,
   output logic [imfp_pkg::BYTE_W-1:0]      rsp_payload_index,
   output logic [imfp_pkg::BYTE_W-1:0]      rsp_payload_byte,
   output logic                            rsp_frame_done,
   output logic [1:0]                      rsp_error_kind,
   output logic [imfp_pkg::BYTE_W-1:0]      rsp_msg_id,
   output logic [imfp_pkg::BYTE_W-1:0]      rsp_msg_len,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [imfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [imfp_pkg::BYTE_W-1:0]      csr_wdata
);
   import imfp_pkg::*;

   cfg_type           cfg;
   result_type        result;
   result_type        rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              advance;

   // move the input register into the result register when the result slot frees
   assign advance = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;

   imfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   imfp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in = req_in_byte;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload_valid = rsp_ff.payload_valid;
   assign rsp_payload_index = rsp_ff.payload_index;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_frame_done = rsp_ff.frame_done;
   assign rsp_error_kind = rsp_ff.error_kind;
   assign rsp_msg_id = rsp_ff.msg_id;
   assign rsp_msg_len = rsp_ff.msg_len;

endmodule
